@@ rtl/core/bvg_pkg.sv @@
package bvg_pkg;

    localparam int SampleW  = 16;
    localparam int OhmW     = 20;
    localparam int ProdW    = SampleW + OhmW + 1;
    localparam int PctW     = 7;
    localparam int LevelW   = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 20;
    localparam int DivStages = 4;
    localparam int DivBits   = SampleW / DivStages;
    localparam int NumW      = SampleW + PctW;
    localparam int PctBitsB  = 4;
    localparam int PctBitsC  = PctW - PctBitsB;

    localparam logic [CfgIdxW-1:0] REG_DIV_TOP   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DIV_BOT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CHEM      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CUST_EMPTY = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CUST_FULL = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_CRIT      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_LOW       = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_FULL      = 3'd7;

    localparam logic [1:0] CHEM_LIION  = 2'd0;
    localparam logic [1:0] CHEM_LFP    = 2'd1;
    localparam logic [1:0] CHEM_CUSTOM = 2'd2;

    localparam logic [LevelW-1:0] LVL_UNKNOWN  = 3'd0;
    localparam logic [LevelW-1:0] LVL_CRITICAL = 3'd1;
    localparam logic [LevelW-1:0] LVL_LOW      = 3'd2;
    localparam logic [LevelW-1:0] LVL_NORMAL   = 3'd3;
    localparam logic [LevelW-1:0] LVL_FULL     = 3'd4;

    localparam logic [SampleW-1:0] MV_MAX         = 16'hFFFF;
    localparam logic [SampleW-1:0] LIION_EMPTY_MV = 16'd3300;
    localparam logic [SampleW-1:0] LIION_FULL_MV  = 16'd4200;
    localparam logic [SampleW-1:0] LFP_EMPTY_MV   = 16'd2800;
    localparam logic [SampleW-1:0] LFP_FULL_MV    = 16'd3650;
    localparam logic [SampleW-1:0] LIION_CRIT_MV  = 16'd3400;
    localparam logic [SampleW-1:0] LIION_LOW_MV   = 16'd3600;
    localparam logic [SampleW-1:0] LIION_FULLT_MV = 16'd4150;
    localparam logic [SampleW-1:0] LFP_CRIT_MV    = 16'd2900;
    localparam logic [SampleW-1:0] LFP_LOW_MV     = 16'd3100;
    localparam logic [SampleW-1:0] LFP_FULLT_MV   = 16'd3550;
    localparam logic [PctW-1:0]    PCT_MAX        = 7'd100;

    typedef struct packed {
        logic [OhmW-1:0]    div_top;
        logic [OhmW-1:0]    div_bot;
        logic [1:0]         chem;
        logic [SampleW-1:0] cust_empty;
        logic [SampleW-1:0] cust_full;
        logic [SampleW-1:0] crit;
        logic [SampleW-1:0] low;
        logic [SampleW-1:0] full;
    } t_cfg;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [OhmW:0] div_step(input logic [OhmW-1:0] rem,
                                               input logic din,
                                               input logic [OhmW-1:0] d);
        logic [OhmW:0] t;
        logic [OhmW:0] s;
        t = {rem, din};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, s[OhmW-1:0]};
        end else begin
            return {1'b0, t[OhmW-1:0]};
        end
    endfunction

endpackage

@@ rtl/core/bvg_cfg_regs.sv @@
module bvg_cfg_regs
    import bvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_top    <= '0;
            r_cfg.div_bot    <= OhmW'(1);
            r_cfg.chem       <= CHEM_LIION;
            r_cfg.cust_empty <= LIION_EMPTY_MV;
            r_cfg.cust_full  <= LIION_FULL_MV;
            r_cfg.crit       <= '0;
            r_cfg.low        <= '0;
            r_cfg.full       <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DIV_TOP:    r_cfg.div_top    <= i_cfg_data;
                REG_DIV_BOT:    r_cfg.div_bot    <= i_cfg_data;
                REG_CHEM:       r_cfg.chem       <= i_cfg_data[1:0];
                REG_CUST_EMPTY: r_cfg.cust_empty <= i_cfg_data[SampleW-1:0];
                REG_CUST_FULL:  r_cfg.cust_full  <= i_cfg_data[SampleW-1:0];
                REG_CRIT:       r_cfg.crit       <= i_cfg_data[SampleW-1:0];
                REG_LOW:        r_cfg.low        <= i_cfg_data[SampleW-1:0];
                REG_FULL:       r_cfg.full       <= i_cfg_data[SampleW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/bvg_div.sv @@
module bvg_div
    import bvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [SampleW-1:0] i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SampleW-1:0] o_sample,
    output logic [SampleW-1:0] o_quot,
    output logic               o_sat,
    output logic               o_zero
);

    // product stage
    logic               r_vld0;
    logic [SampleW-1:0] r_smp0;
    logic [ProdW-1:0]   r_prod0;
    logic [ProdW-1:0]   n_prod0;
    logic [OhmW:0]      ohm_sum;
    logic               en0;

    // division stages, DivBits quotient bits each
    logic               r_vld [DivStages];
    logic [SampleW-1:0] r_smp [DivStages];
    logic [OhmW-1:0]    r_rem [DivStages];
    logic [SampleW-1:0] r_low [DivStages];
    logic [SampleW-1:0] r_q   [DivStages];
    logic               r_sat [DivStages];
    logic               r_zero[DivStages];

    logic               n_vld [DivStages];
    logic [SampleW-1:0] n_smp [DivStages];
    logic [OhmW-1:0]    n_rem [DivStages];
    logic [SampleW-1:0] n_low [DivStages];
    logic [SampleW-1:0] n_q   [DivStages];
    logic               n_sat [DivStages];
    logic               n_zero[DivStages];
    logic               en    [DivStages];

    assign ohm_sum = {1'b0, i_cfg.div_top} + {1'b0, i_cfg.div_bot};
    assign n_prod0 = {{(ProdW-SampleW){1'b0}}, i_sample}
                   * {{(ProdW-OhmW-1){1'b0}}, ohm_sum};

    always_comb begin
        en[DivStages-1] = !r_vld[DivStages-1] || i_ready;
        for (int k = DivStages-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        en0 = !r_vld0 || en[0];
    end

    assign o_ready = en0;

    always_comb begin
        logic [OhmW-1:0]    rem;
        logic [SampleW-1:0] low;
        logic [SampleW-1:0] q;
        logic [OhmW:0]      st;
        for (int k = 0; k < DivStages; k++) begin
            if (k == 0) begin
                n_vld[k]  = r_vld0;
                n_smp[k]  = r_smp0;
                rem       = r_prod0[ProdW-2:SampleW];
                low       = r_prod0[SampleW-1:0];
                q         = '0;
                if (i_cfg.div_bot == '0) begin
                    n_sat[k]  = (r_smp0 != '0);
                    n_zero[k] = (r_smp0 == '0);
                end else begin
                    n_sat[k]  = (r_prod0[ProdW-1:SampleW] >= {1'b0, i_cfg.div_bot});
                    n_zero[k] = 1'b0;
                end
            end else begin
                n_vld[k]  = r_vld[k-1];
                n_smp[k]  = r_smp[k-1];
                rem       = r_rem[k-1];
                low       = r_low[k-1];
                q         = r_q[k-1];
                n_sat[k]  = r_sat[k-1];
                n_zero[k] = r_zero[k-1];
            end
            for (int j = 0; j < DivBits; j++) begin
                st  = div_step(rem, low[SampleW-1], i_cfg.div_bot);
                rem = st[OhmW-1:0];
                q   = {q[SampleW-2:0], st[OhmW]};
                low = {low[SampleW-2:0], 1'b0};
            end
            n_rem[k] = rem;
            n_low[k] = low;
            n_q[k]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            for (int k = 0; k < DivStages; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (en0) begin
                r_vld0 <= i_valid;
            end
            for (int k = 0; k < DivStages; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_smp0  <= i_sample;
            r_prod0 <= n_prod0;
        end
        for (int k = 0; k < DivStages; k++) begin
            if (en[k]) begin
                r_smp[k]  <= n_smp[k];
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_q[k]    <= n_q[k];
                r_sat[k]  <= n_sat[k];
                r_zero[k] <= n_zero[k];
            end
        end
    end

    assign o_valid  = r_vld[DivStages-1];
    assign o_sample = r_smp[DivStages-1];
    assign o_quot   = r_q[DivStages-1];
    assign o_sat    = r_sat[DivStages-1];
    assign o_zero   = r_zero[DivStages-1];

endmodule

@@ rtl/core/bvg_grade.sv @@
module bvg_grade
    import bvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [SampleW-1:0] i_sample,
    input  logic [SampleW-1:0] i_quot,
    input  logic               i_sat,
    input  logic               i_zero,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SampleW-1:0] o_sample_echo_mv,
    output logic [SampleW-1:0] o_battery_mv,
    output logic [PctW-1:0]    o_charge_percent,
    output logic [LevelW-1:0]  o_level_class
);

    logic en_a, en_b, en_c;

    // stage A: battery voltage, limits, scaled numerator
    logic               r_vld_a;
    logic [SampleW-1:0] r_smp_a, r_v_a, r_den_a;
    logic [NumW-1:0]    r_num_a;
    logic               r_le_a, r_ge_a;

    logic [SampleW-1:0] v, lim_lo, lim_hi, diff;
    logic [NumW-1:0]    n_num;

    // stage B: upper quotient bits
    logic                r_vld_b;
    logic [SampleW-1:0]  r_smp_b, r_v_b, r_den_b;
    logic [OhmW-1:0]     r_rem_b;
    logic [PctBitsC-1:0] r_low_b;
    logic [PctBitsB-1:0] r_q_b;
    logic                r_le_b, r_ge_b;
    logic [OhmW-1:0]     n_rem_b;
    logic [PctBitsB-1:0] n_q_b;

    // stage C: output register
    logic               r_vld_c;
    logic [SampleW-1:0] r_smp_c, r_v_c;
    logic [PctW-1:0]    r_pct_c;
    logic [LevelW-1:0]  r_lvl_c;
    logic [PctW-1:0]    n_pct;
    logic [LevelW-1:0]  n_lvl;
    logic [SampleW-1:0] th_crit, th_low, th_full;
    logic               lfp;

    assign en_c    = !r_vld_c || i_ready;
    assign en_b    = !r_vld_b || en_c;
    assign en_a    = !r_vld_a || en_b;
    assign o_ready = en_a;

    always_comb begin
        v = i_zero ? '0 : (i_sat ? MV_MAX : i_quot);
        case (i_cfg.chem)
            CHEM_LFP: begin
                lim_lo = LFP_EMPTY_MV;
                lim_hi = LFP_FULL_MV;
            end
            CHEM_CUSTOM: begin
                lim_lo = i_cfg.cust_empty;
                lim_hi = i_cfg.cust_full;
            end
            default: begin
                lim_lo = LIION_EMPTY_MV;
                lim_hi = LIION_FULL_MV;
            end
        endcase
        diff  = v - lim_lo;
        // x100 = x64 + x32 + x4
        n_num = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
    end

    always_comb begin
        logic [OhmW-1:0]  rem;
        logic [OhmW:0]    st;
        rem = {{(OhmW-SampleW){1'b0}}, r_num_a[NumW-1:PctW]};
        for (int j = 0; j < PctBitsB; j++) begin
            st       = div_step(rem, r_num_a[PctW-1-j], {{(OhmW-SampleW){1'b0}}, r_den_a});
            rem      = st[OhmW-1:0];
            n_q_b[PctBitsB-1-j] = st[OhmW];
        end
        n_rem_b = rem;
    end

    always_comb begin
        logic [OhmW-1:0]     rem;
        logic [OhmW:0]       st;
        logic [PctBitsC-1:0] qc;
        rem = r_rem_b;
        for (int j = 0; j < PctBitsC; j++) begin
            st  = div_step(rem, r_low_b[PctBitsC-1-j], {{(OhmW-SampleW){1'b0}}, r_den_b});
            rem = st[OhmW-1:0];
            qc[PctBitsC-1-j] = st[OhmW];
        end
        if (r_le_b) begin
            n_pct = '0;
        end else if (r_ge_b) begin
            n_pct = PCT_MAX;
        end else begin
            n_pct = {r_q_b, qc};
        end
    end

    always_comb begin
        lfp     = (i_cfg.chem == CHEM_LFP);
        th_crit = (i_cfg.crit != '0) ? i_cfg.crit : (lfp ? LFP_CRIT_MV  : LIION_CRIT_MV);
        th_low  = (i_cfg.low  != '0) ? i_cfg.low  : (lfp ? LFP_LOW_MV   : LIION_LOW_MV);
        th_full = (i_cfg.full != '0) ? i_cfg.full : (lfp ? LFP_FULLT_MV : LIION_FULLT_MV);
        if (r_v_b == '0) begin
            n_lvl = LVL_UNKNOWN;
        end else if (r_v_b < th_crit) begin
            n_lvl = LVL_CRITICAL;
        end else if (r_v_b < th_low) begin
            n_lvl = LVL_LOW;
        end else if (r_v_b >= th_full) begin
            n_lvl = LVL_FULL;
        end else begin
            n_lvl = LVL_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_valid;
            end
            if (en_b) begin
                r_vld_b <= r_vld_a;
            end
            if (en_c) begin
                r_vld_c <= r_vld_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_smp_a <= i_sample;
            r_v_a   <= v;
            r_den_a <= lim_hi - lim_lo;
            r_num_a <= n_num;
            r_le_a  <= (v <= lim_lo);
            r_ge_a  <= (v >= lim_hi);
        end
        if (en_b) begin
            r_smp_b <= r_smp_a;
            r_v_b   <= r_v_a;
            r_den_b <= r_den_a;
            r_rem_b <= n_rem_b;
            r_low_b <= r_num_a[PctBitsC-1:0];
            r_q_b   <= n_q_b;
            r_le_b  <= r_le_a;
            r_ge_b  <= r_ge_a;
        end
        if (en_c) begin
            r_smp_c <= r_smp_b;
            r_v_c   <= r_v_b;
            r_pct_c <= n_pct;
            r_lvl_c <= n_lvl;
        end
    end

    assign o_valid          = r_vld_c;
    assign o_sample_echo_mv = r_smp_c;
    assign o_battery_mv     = r_v_c;
    assign o_charge_percent = r_pct_c;
    assign o_level_class    = r_lvl_c;

endmodule

@@ rtl/core/battery_voltage_gauge_top.sv @@
// Channel   Handshake            Payload
// sample    i_valid / o_ready    i_sample_mv
// result    o_valid / i_ready    o_sample_echo_mv, o_battery_mv, o_charge_percent,
//                                o_level_class
// config    i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One sample per cycle unless the output stalls; stages: product, four divider
// stages of four quotient bits each, limits, percent division (4 + 3 bits), output.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
module battery_voltage_gauge_top
    import bvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SampleW-1:0]  i_sample_mv,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SampleW-1:0]  o_sample_echo_mv,
    output logic [SampleW-1:0]  o_battery_mv,
    output logic [PctW-1:0]     o_charge_percent,
    output logic [LevelW-1:0]   o_level_class
);

    t_cfg               cfg;
    logic               div_valid;
    logic               div_ready;
    logic [SampleW-1:0] div_sample;
    logic [SampleW-1:0] div_quot;
    logic               div_sat;
    logic               div_zero;

    bvg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bvg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample_mv),
        .o_valid  (div_valid),
        .i_ready  (div_ready),
        .o_sample (div_sample),
        .o_quot   (div_quot),
        .o_sat    (div_sat),
        .o_zero   (div_zero)
    );

    bvg_grade u_grade (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (div_valid),
        .o_ready          (div_ready),
        .i_sample         (div_sample),
        .i_quot           (div_quot),
        .i_sat            (div_sat),
        .i_zero           (div_zero),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sample_echo_mv (o_sample_echo_mv),
        .o_battery_mv     (o_battery_mv),
        .o_charge_percent (o_charge_percent),
        .o_level_class    (o_level_class)
    );

endmodule

@@ tb/battery_voltage_gauge_top_tb.sv @@
`timescale 1ns / 100ps

module battery_voltage_gauge_top_tb;
    import bvg_pkg::*;

    localparam int                 Phases        = 12;
    localparam int                 ItemsPerPhase = 40;
    localparam int                 HoldPhase     = 5;
    localparam int                 HoldItems     = 60;
    localparam int                 LongHold      = 300;
    localparam int                 CycleLimit    = 200000;
    localparam int                 ReportLimit   = 10;
    localparam logic [OhmW-1:0]    OhmMax        = {OhmW{1'b1}};
    localparam logic [1:0]         ChemSpare     = 2'd3;

    typedef struct {
        logic [SampleW-1:0] echo_mv;
        logic [SampleW-1:0] batt_mv;
        logic [PctW-1:0]    pct;
        logic [LevelW-1:0]  level;
    } t_gauge_reading;

    class gauge_scoreboard;
        t_cfg           cfg;
        t_gauge_reading readings_q[$];
        int             mismatches;

        function new();
            mismatches      = 0;
            cfg.div_top     = '0;
            cfg.div_bot     = OhmW'(1);
            cfg.chem        = CHEM_LIION;
            cfg.cust_empty  = LIION_EMPTY_MV;
            cfg.cust_full   = LIION_FULL_MV;
            cfg.crit        = '0;
            cfg.low         = '0;
            cfg.full        = '0;
        endfunction

        function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
            case (idx)
                REG_DIV_TOP:    cfg.div_top    = data[OhmW-1:0];
                REG_DIV_BOT:    cfg.div_bot    = data[OhmW-1:0];
                REG_CHEM:       cfg.chem       = data[1:0];
                REG_CUST_EMPTY: cfg.cust_empty = data[SampleW-1:0];
                REG_CUST_FULL:  cfg.cust_full  = data[SampleW-1:0];
                REG_CRIT:       cfg.crit       = data[SampleW-1:0];
                REG_LOW:        cfg.low        = data[SampleW-1:0];
                REG_FULL:       cfg.full       = data[SampleW-1:0];
                default: ;
            endcase
        endfunction

        function logic [SampleW-1:0] undivided_mv(input logic [SampleW-1:0] mv);
            logic [63:0] prod;
            logic [63:0] quo;
            logic [63:0] top64;
            logic [63:0] bot64;
            if (cfg.div_bot == '0) begin
                return (mv == '0) ? '0 : MV_MAX;
            end
            top64 = 64'(cfg.div_top);
            bot64 = 64'(cfg.div_bot);
            prod  = 64'(mv);
            prod  = prod * (top64 + bot64);
            quo   = prod / bot64;
            return (quo > 64'(MV_MAX)) ? MV_MAX : quo[SampleW-1:0];
        endfunction

        function logic [PctW-1:0] charge_of(input logic [SampleW-1:0] v);
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] num;
            logic [31:0] quo;
            lo = 32'(LIION_EMPTY_MV);
            hi = 32'(LIION_FULL_MV);
            if (cfg.chem == CHEM_LFP) begin
                lo = 32'(LFP_EMPTY_MV);
                hi = 32'(LFP_FULL_MV);
            end else if (cfg.chem == CHEM_CUSTOM) begin
                lo = 32'(cfg.cust_empty);
                hi = 32'(cfg.cust_full);
            end
            if (32'(v) <= lo) return '0;
            if (32'(v) >= hi) return PCT_MAX;
            num = (32'(v) - lo) * 32'(PCT_MAX);
            quo = num / (hi - lo);
            return quo[PctW-1:0];
        endfunction

        function logic [LevelW-1:0] level_of(input logic [SampleW-1:0] v);
            logic               lfp;
            logic [SampleW-1:0] crit;
            logic [SampleW-1:0] low;
            logic [SampleW-1:0] fullt;
            lfp   = (cfg.chem == CHEM_LFP);
            crit  = (cfg.crit != '0) ? cfg.crit : (lfp ? LFP_CRIT_MV : LIION_CRIT_MV);
            low   = (cfg.low != '0) ? cfg.low : (lfp ? LFP_LOW_MV : LIION_LOW_MV);
            fullt = (cfg.full != '0) ? cfg.full : (lfp ? LFP_FULLT_MV : LIION_FULLT_MV);
            if (v == '0) return LVL_UNKNOWN;
            if (v < crit) return LVL_CRITICAL;
            if (v < low) return LVL_LOW;
            if (v >= fullt) return LVL_FULL;
            return LVL_NORMAL;
        endfunction

        function void note_sample(input logic [SampleW-1:0] mv);
            t_gauge_reading r;
            r.echo_mv = mv;
            r.batt_mv = undivided_mv(mv);
            r.pct     = charge_of(r.batt_mv);
            r.level   = level_of(r.batt_mv);
            readings_q.push_back(r);
        endfunction

        function int pending();
            return readings_q.size();
        endfunction

        function void check_result(input logic [SampleW-1:0] echo_mv,
                                   input logic [SampleW-1:0] batt_mv,
                                   input logic [PctW-1:0]    pct,
                                   input logic [LevelW-1:0]  level);
            t_gauge_reading r;
            if (readings_q.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display("%0t: unexpected result: echo %0d batt %0d pct %0d lvl %0d",
                             $realtime, echo_mv, batt_mv, pct, level);
                end
                return;
            end
            r = readings_q.pop_front();
            if (echo_mv !== r.echo_mv || batt_mv !== r.batt_mv ||
                pct !== r.pct || level !== r.level) begin
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display("%0t: exp/act echo %0d/%0d batt %0d/%0d pct %0d/%0d lvl %0d/%0d",
                             $realtime, r.echo_mv, echo_mv, r.batt_mv, batt_mv,
                             r.pct, pct, r.level, level);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [SampleW-1:0]  i_sample_mv;
    logic                o_valid;
    logic                i_ready;
    logic [SampleW-1:0]  o_sample_echo_mv;
    logic [SampleW-1:0]  o_battery_mv;
    logic [PctW-1:0]     o_charge_percent;
    logic [LevelW-1:0]   o_level_class;

    gauge_scoreboard sb;
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;

    battery_voltage_gauge_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_mv      (i_sample_mv),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sample_echo_mv (o_sample_echo_mv),
        .o_battery_mv     (o_battery_mv),
        .o_charge_percent (o_charge_percent),
        .o_level_class    (o_level_class)
    );

    always #6 i_clk = ~i_clk;

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_setup(input logic [CfgDataW-1:0] top, input logic [CfgDataW-1:0] bot,
                              input logic [CfgDataW-1:0] chem,
                              input logic [CfgDataW-1:0] empty, input logic [CfgDataW-1:0] full,
                              input logic [CfgDataW-1:0] crit, input logic [CfgDataW-1:0] low,
                              input logic [CfgDataW-1:0] fullt);
        write_reg(REG_DIV_TOP, top);
        write_reg(REG_DIV_BOT, bot);
        write_reg(REG_CHEM, chem);
        write_reg(REG_CUST_EMPTY, empty);
        write_reg(REG_CUST_FULL, full);
        write_reg(REG_CRIT, crit);
        write_reg(REG_LOW, low);
        write_reg(REG_FULL, fullt);
        i_cfg_wr_en <= 1'b0;
    endtask

    // upper data bits carry noise that the narrow registers must drop
    function automatic logic [CfgDataW-1:0] noisy(input logic [SampleW-1:0] v);
        logic [CfgDataW-1:0] d;
        d = CfgDataW'($urandom);
        d[SampleW-1:0] = v;
        return d;
    endfunction

    function automatic logic [SampleW-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0, 1:    return '0;
            2:       return MV_MAX;
            default: return SampleW'($urandom_range(2000, 5000));
        endcase
    endfunction

    task automatic random_setup(input int ph);
        logic [OhmW-1:0]     top;
        logic [OhmW-1:0]     bot;
        logic [CfgDataW-1:0] chem;
        logic [SampleW-1:0]  empty;
        logic [SampleW-1:0]  full;
        logic [SampleW-1:0]  crit;
        logic [SampleW-1:0]  low;
        logic [SampleW-1:0]  fullt;
        case ($urandom_range(0, 7))
            0:       bot = '0;
            1:       bot = OhmMax;
            2:       bot = OhmW'(1);
            default: bot = OhmW'($urandom_range(1, 32'(OhmMax)));
        endcase
        case ($urandom_range(0, 5))
            0:       top = '0;
            1:       top = OhmMax;
            2:       top = OhmW'($urandom);
            default: top = OhmW'(32'(bot) * $urandom_range(0, 3) + $urandom_range(0, 1000));
        endcase
        chem     = CfgDataW'($urandom);
        chem[1:0] = 2'($urandom_range(0, 3));
        empty = SampleW'($urandom_range(2000, 5000));
        full  = ($urandom_range(0, 7) == 0) ? empty : SampleW'($urandom_range(2000, 5000));
        crit  = pick_threshold();
        low   = pick_threshold();
        fullt = pick_threshold();
        case (ph)
            0: begin
                top = OhmMax;
                bot = OhmW'(1);
            end
            1: begin
                top = '0;
                bot = OhmMax;
            end
            2: bot = '0;
            3: begin
                chem[1:0] = ChemSpare;
                crit  = MV_MAX;
                low   = MV_MAX;
                fullt = MV_MAX;
            end
            4: begin
                chem[1:0] = CHEM_CUSTOM;
                full = empty;
            end
            6: begin
                chem[1:0] = CHEM_CUSTOM;
                empty = '0;
                full  = MV_MAX;
            end
            default: ;
        endcase
        load_setup(top, bot, chem, noisy(empty), noisy(full), noisy(crit), noisy(low),
                   noisy(fullt));
    endtask

    // mostly aim at battery voltages around the chemistry windows
    function automatic logic [SampleW-1:0] pick_sample();
        logic [63:0] v;
        logic [63:0] top64;
        logic [63:0] bot64;
        top64 = 64'(sb.cfg.div_top);
        bot64 = 64'(sb.cfg.div_bot);
        if ($urandom_range(0, 3) == 0 || bot64 == 0) return SampleW'($urandom);
        v = 64'($urandom_range(0, 5500));
        v = (v * bot64) / (top64 + bot64);
        return v[SampleW-1:0];
    endfunction

    task automatic send_sample(input logic [SampleW-1:0] mv);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_mv <= mv;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        sb.note_sample(mv);
    endtask

    task automatic finish_burst();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            sb.check_result(o_sample_echo_mv, o_battery_mv, o_charge_percent, o_level_class);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("battery_voltage_gauge_top test failed");
        $finish;
    end

    initial begin : stimulus
        logic [SampleW-1:0] directed_mv[$];
        int                 n;
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_DIV_TOP;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample_mv <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setup: unity divider, Li-ion window and default thresholds
        directed_mv = '{16'd0, 16'd1, 16'd3300, 16'd3301, 16'd3399, 16'd3400, 16'd3599,
                        16'd3600, 16'd4149, 16'd4150, 16'd4199, 16'd4200, 16'd32768, MV_MAX};
        foreach (directed_mv[i]) send_sample(directed_mv[i]);
        finish_burst();

        // zero bottom resistor
        load_setup(CfgDataW'(5), '0, CfgDataW'(CHEM_LIION), CfgDataW'(LIION_EMPTY_MV),
                   CfgDataW'(LIION_FULL_MV), '0, '0, '0);
        send_sample(16'd0);
        send_sample(16'd1234);
        finish_burst();

        // custom window with full below empty, thresholds out of order
        load_setup('0, CfgDataW'(1), CfgDataW'(CHEM_CUSTOM), CfgDataW'(4000), CfgDataW'(3000),
                   CfgDataW'(3200), CfgDataW'(4500), CfgDataW'(3000));
        send_sample(16'd3100);
        send_sample(16'd3500);
        send_sample(16'd4001);
        send_sample(16'd4600);
        finish_burst();

        // LiFePO4 behind a 1:1 divider
        load_setup(CfgDataW'(1), CfgDataW'(1), CfgDataW'(CHEM_LFP), CfgDataW'(LIION_EMPTY_MV),
                   CfgDataW'(LIION_FULL_MV), '0, '0, '0);
        send_sample(16'd1450);
        send_sample(16'd1612);
        send_sample(16'd1825);
        finish_burst();

        // spare chemistry code with the largest ratio
        load_setup(OhmMax, CfgDataW'(1), CfgDataW'(ChemSpare), CfgDataW'(LIION_EMPTY_MV),
                   CfgDataW'(LIION_FULL_MV), '0, '0, '0);
        send_sample(16'd0);
        send_sample(16'd1);
        finish_burst();

        for (int ph = 0; ph < Phases; ph++) begin
            random_setup(ph);
            idle_on = (ph % 4) != 3;
            n = ItemsPerPhase;
            if (ph == HoldPhase) begin
                hold_cycles = LongHold;
                n = HoldItems;
            end
            repeat (n) send_sample(pick_sample());
            finish_burst();
        end
        idle_on = 1'b1;

        repeat (12) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("battery_voltage_gauge_top test passed");
        end else begin
            $display("battery_voltage_gauge_top test failed");
        end
        $finish;
    end

endmodule

@@ battery_voltage_gauge_top.f @@
rtl/core/bvg_pkg.sv
rtl/core/bvg_cfg_regs.sv
rtl/core/bvg_div.sv
rtl/core/bvg_grade.sv
rtl/core/battery_voltage_gauge_top.sv
tb/battery_voltage_gauge_top_tb.sv
